// ===== rtl/core/lsdh_pkg.sv =====
`timescale 1ns / 1ps
package lsdh_pkg;

   localparam int LEAF_COUNT_DEF = 1024;
   localparam int DIGIT_KINDS    = 10;
   localparam int DIGIT_BITS     = 6;
   localparam int HIST_W         = DIGIT_KINDS * DIGIT_BITS;
   localparam int SUM_W          = 16;
   localparam int IDX_W          = 10;
   localparam int USED_W         = 11;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_USED_LEAVES = 3'd0;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLR_INIT,
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_RESULT
   } ctl_state_type;

   typedef struct packed {
      logic clr_start;
      logic load;
      logic write;
      logic read;
      logic publish;
   } ctl_cmd_type;

   typedef struct packed {
      logic at_last;
      logic empty;
      logic query;
      logic out_busy;
      logic cfg_hit;
   } ctl_sts_type;

endpackage

// ===== rtl/core/lsdh_ram.sv =====
`timescale 1ns / 1ps
module lsdh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/lsdh_ctrl.sv =====
`timescale 1ns / 1ps
module lsdh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lsdh_pkg::ctl_sts_type sts,
   output lsdh_pkg::ctl_cmd_type cmd
);
   import lsdh_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLR_INIT: begin
            cmd.clr_start = 1'b1;
            state_in      = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd.write = 1'b1;
            if (sts.at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.empty) begin
               state_in = sts.query ? ST_RESULT : ST_IDLE;
            end else begin
               state_in = sts.query ? ST_READ : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            if (sts.at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            if (sts.at_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!sts.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLR_INIT;
         end
      endcase
      // A used_leaves write wipes the store.
      if (sts.cfg_hit) begin
         state_in = ST_CLR_INIT;
      end
   end
endmodule

// ===== rtl/core/lsdh_datapath.sv =====
`timescale 1ns / 1ps
module lsdh_datapath #(
   parameter int LEAF_COUNT = lsdh_pkg::LEAF_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_operation,
   input  logic [lsdh_pkg::IDX_W-1:0]             req_first_index,
   input  logic [lsdh_pkg::IDX_W-1:0]             req_last_index,
   input  logic [lsdh_pkg::HIST_W-1:0]            req_digit_counts,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic [lsdh_pkg::DIGIT_KINDS-1:0][lsdh_pkg::SUM_W-1:0] rsp_sums,
   output logic                                   rsp_range_empty,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [lsdh_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [lsdh_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [lsdh_pkg::CSR_DATA_W-1:0]        prdata,
   input  lsdh_pkg::ctl_cmd_type                  cmd,
   output lsdh_pkg::ctl_sts_type                  sts
);
   import lsdh_pkg::*;

   localparam int LA = $clog2(LEAF_COUNT);
   localparam int CW = $clog2(LEAF_COUNT + 1);
   localparam int XW = (CW > USED_W) ? CW : USED_W;
   localparam logic [XW-1:0] LEAF_X = XW'(LEAF_COUNT);
   localparam logic [LA-1:0] LAST_LEAF = LA'(LEAF_COUNT - 1);

   logic [XW-1:0]     used_ff;
   logic [XW-1:0]     used_in;
   logic [XW-1:0]     wr_val;
   logic              addr_hit;
   logic              cfg_hit;
   logic [LA-1:0]     cursor_ff;
   logic [LA-1:0]     last_ff;
   logic [HIST_W-1:0] hist_ff;
   logic              query_ff;
   logic              empty_ff;
   logic              rd_pend_ff;
   logic              rsp_valid_ff;
   logic              rsp_empty_ff;
   logic [DIGIT_KINDS-1:0][SUM_W-1:0] acc_ff;
   logic [DIGIT_KINDS-1:0][SUM_W-1:0] acc_in;
   logic [DIGIT_KINDS-1:0][SUM_W-1:0] sums_ff;
   logic [XW-1:0]     a_x;
   logic [XW-1:0]     b_x;
   logic [XW-1:0]     b_clip;
   logic              req_empty;
   logic [HIST_W-1:0] rdata;
   logic [SUM_W:0]    wide;

   // Configuration register, clamped to 1..LEAF_COUNT. Registers are decoded by
   // word index; the byte-offset bits are not looked at.
   assign addr_hit = (paddr[CSR_ADDR_W-1:2] == ADDR_USED_LEAVES[CSR_ADDR_W-1:2]);
   assign cfg_hit  = psel && penable && pwrite && addr_hit;
   assign wr_val   = XW'(pwdata[USED_W-1:0]);

   always_comb begin
      used_in = wr_val;
      if (wr_val == '0) begin
         used_in = XW'(1);
      end else if (wr_val > LEAF_X) begin
         used_in = LEAF_X;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= LEAF_X;
      end else if (cfg_hit) begin
         used_ff <= used_in;
      end
   end

   assign prdata = addr_hit ? CSR_DATA_W'(used_ff) : '0;

   // Range check and clipping of the incoming item.
   assign a_x       = XW'(req_first_index);
   assign b_x       = XW'(req_last_index);
   assign req_empty = (a_x > b_x) || (a_x >= used_ff);
   assign b_clip    = (b_x >= used_ff) ? (used_ff - XW'(1)) : b_x;

   always_ff @(posedge clock) begin
      if (cmd.clr_start) begin
         cursor_ff <= '0;
         last_ff   <= LAST_LEAF;
         hist_ff   <= '0;
      end else if (cmd.load) begin
         cursor_ff <= a_x[LA-1:0];
         last_ff   <= b_clip[LA-1:0];
         hist_ff   <= req_digit_counts;
         query_ff  <= (req_operation == OP_QUERY);
         empty_ff  <= req_empty;
      end else if (cmd.write || cmd.read) begin
         cursor_ff <= cursor_ff + LA'(1);
      end
   end

   lsdh_ram #(
      .WIDTH (HIST_W),
      .DEPTH (LEAF_COUNT)
   ) u_leaf_ram (
      .clock (clock),
      .addr  (cursor_ff),
      .we    (cmd.write),
      .wdata (hist_ff),
      .rdata (rdata)
   );

   // Saturating per-digit accumulation of leaves as they come out of the RAM.
   always_comb begin
      acc_in = acc_ff;
      wide   = '0;
      for (int d = 0; d < DIGIT_KINDS; d++) begin
         wide = {1'b0, acc_ff[d]} + (SUM_W + 1)'(rdata[d*DIGIT_BITS +: DIGIT_BITS]);
         acc_in[d] = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.read;
      end
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (rd_pend_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.publish) begin
         sums_ff      <= acc_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sums        = sums_ff;
   assign rsp_range_empty = rsp_empty_ff;

   assign sts.at_last  = (cursor_ff == last_ff);
   assign sts.empty    = empty_ff;
   assign sts.query    = query_ff;
   assign sts.out_busy = rsp_valid_ff && rsp_stall;
   assign sts.cfg_hit  = cfg_hit;
endmodule

// ===== rtl/core/lazy_segment_tree_digit_histogram.sv =====
`timescale 1ns / 1ps
// Digit-histogram range store. Each leaf holds ten 6-bit digit counts.
// Request channel (req_valid / req_stall): an assign beat writes one histogram
// to every leaf of an inclusive index range and produces no response; a query
// beat produces one response beat with the ten per-digit sums over the range,
// saturated at 65535, and range_empty set when the range misses every leaf.
// Ranges past the last used leaf are clipped to it.
// Throughput is set by the single-port leaf RAM, touched one leaf per cycle:
// req_stall stays high while an assign or query is in hand, until its sweep is
// done and, for a query, until its response is registered.
// The response sits in an output register, so a stalled response does not
// block the next request; a new query waits only if the earlier response is
// still held when its own result is ready.
// Reset (synchronous, active high) sets used_leaves to LEAF_COUNT and starts
// a clearing pass that zeroes the whole leaf RAM, one leaf per cycle;
// req_stall is high meanwhile. A write of used_leaves (APB, address 0)
// starts the same pass. pready is always high.
module lazy_segment_tree_digit_histogram #(
   parameter int LEAF_COUNT = lsdh_pkg::LEAF_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [lsdh_pkg::IDX_W-1:0]        req_first_index,
   input  logic [lsdh_pkg::IDX_W-1:0]        req_last_index,
   input  logic [lsdh_pkg::HIST_W-1:0]       req_digit_counts,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit0,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit1,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit2,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit3,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit4,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit5,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit6,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit7,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit8,
   output logic [lsdh_pkg::SUM_W-1:0]        rsp_sum_digit9,
   output logic                              rsp_range_empty,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lsdh_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lsdh_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lsdh_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import lsdh_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic [DIGIT_KINDS-1:0][SUM_W-1:0] sums;

   // The controller sequences clear, write and read sweeps over the leaf RAM.
   lsdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the RAM, the sweep cursor, the accumulators and the
   // configuration register.
   lsdh_datapath #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_first_index  (req_first_index),
      .req_last_index   (req_last_index),
      .req_digit_counts (req_digit_counts),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_sums         (sums),
      .rsp_range_empty  (rsp_range_empty),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .cmd              (cmd),
      .sts              (sts)
   );

   assign pready = 1'b1;

   assign rsp_sum_digit0 = sums[0];
   assign rsp_sum_digit1 = sums[1];
   assign rsp_sum_digit2 = sums[2];
   assign rsp_sum_digit3 = sums[3];
   assign rsp_sum_digit4 = sums[4];
   assign rsp_sum_digit5 = sums[5];
   assign rsp_sum_digit6 = sums[6];
   assign rsp_sum_digit7 = sums[7];
   assign rsp_sum_digit8 = sums[8];
   assign rsp_sum_digit9 = sums[9];
endmodule

// ===== tb/sv/lazy_segment_tree_digit_histogram_tb.sv =====
`timescale 1ns / 1ps

module lazy_segment_tree_digit_histogram_tb;
   import lsdh_pkg::*;

   // One response beat: ten per-digit sums and the empty flag.
   typedef struct packed {
      logic [DIGIT_KINDS-1:0][SUM_W-1:0] sums;
      logic                              empty;
   } range_sums_type;

   // Scoreboard: a flat copy of the leaf array and the queue of pending query
   // sums. Saturating adds of non-negative counts do not depend on grouping, so
   // a flat array gives the same sums as the block.
   class digit_hist_board;
      logic [HIST_W-1:0] leaves[LEAF_COUNT_DEF];
      int                span;
      range_sums_type    pending_sums[$];
      int                mismatches;

      function new();
         span = LEAF_COUNT_DEF;
         mismatches = 0;
         foreach (leaves[i]) leaves[i] = '0;
      endfunction

      // A write of used_leaves clamps the value and clears the whole store.
      function void set_span(logic [CSR_DATA_W-1:0] value);
         int v;
         v = int'(value[USED_W-1:0]);
         if (v < 1) v = 1;
         if (v > LEAF_COUNT_DEF) v = LEAF_COUNT_DEF;
         span = v;
         foreach (leaves[i]) leaves[i] = '0;
      endfunction

      function void note_request(logic op, logic [IDX_W-1:0] first,
                                 logic [IDX_W-1:0] last, logic [HIST_W-1:0] hist);
         int             a;
         int             b;
         int             acc[DIGIT_KINDS];
         bit             is_empty;
         range_sums_type exp;
         a = int'(first);
         b = int'(last);
         is_empty = (a > b) || (a >= span);
         if (!is_empty && b > span - 1) b = span - 1;
         if (op == OP_ASSIGN) begin
            if (!is_empty)
               for (int i = a; i <= b; i++) leaves[i] = hist;
            return;
         end
         foreach (acc[d]) acc[d] = 0;
         if (!is_empty)
            for (int i = a; i <= b; i++)
               for (int d = 0; d < DIGIT_KINDS; d++)
                  acc[d] += int'(leaves[i][d*DIGIT_BITS +: DIGIT_BITS]);
         for (int d = 0; d < DIGIT_KINDS; d++)
            exp.sums[d] = (acc[d] > 65535) ? 16'hFFFF : acc[d][SUM_W-1:0];
         exp.empty = is_empty;
         pending_sums.push_back(exp);
      endfunction

      function void report(string what, range_sums_type exp, range_sums_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, exp, got);
      endfunction

      function void check_response(range_sums_type got);
         range_sums_type exp;
         if (pending_sums.size() == 0) begin
            exp = '0;
            report("unexpected beat", exp, got);
            return;
         end
         exp = pending_sums.pop_front();
         for (int d = 0; d < DIGIT_KINDS; d++)
            if (exp.sums[d] !== got.sums[d]) begin
               report($sformatf("sum_digit%0d", d), exp, got);
               return;
            end
         if (exp.empty !== got.empty) report("range_empty", exp, got);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_operation;
   logic [IDX_W-1:0]      req_first_index;
   logic [IDX_W-1:0]      req_last_index;
   logic [HIST_W-1:0]     req_digit_counts;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SUM_W-1:0]      rsp_sum[DIGIT_KINDS];
   logic                  rsp_range_empty;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   digit_hist_board board;

   // When burst is set, neither side idles. When hold_off is set, the
   // receiver stalls for a long stretch so that the block backs up.
   bit burst;
   bit hold_off;

   lazy_segment_tree_digit_histogram u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_first_index(req_first_index),
      .req_last_index(req_last_index), .req_digit_counts(req_digit_counts),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sum_digit0(rsp_sum[0]), .rsp_sum_digit1(rsp_sum[1]),
      .rsp_sum_digit2(rsp_sum[2]), .rsp_sum_digit3(rsp_sum[3]),
      .rsp_sum_digit4(rsp_sum[4]), .rsp_sum_digit5(rsp_sum[5]),
      .rsp_sum_digit6(rsp_sum[6]), .rsp_sum_digit7(rsp_sum[7]),
      .rsp_sum_digit8(rsp_sum[8]), .rsp_sum_digit9(rsp_sum[9]),
      .rsp_range_empty(rsp_range_empty),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Safety net: the slowest legal run is far below this.
   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   // Response monitor. Outputs are read at the edge, before any update lands,
   // so the sampled values are the ones the beat carried.
   always @(posedge clock) begin
      range_sums_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         for (int d = 0; d < DIGIT_KINDS; d++) got.sums[d] = rsp_sum[d];
         got.empty = rsp_range_empty;
         board.check_response(got);
      end
   end

   // Receiver: for every beat it draws a random stall, none in burst mode, then
   // takes the beat. A long hold-off is inserted once on request.
   initial begin
      int k;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         k = burst ? 0 : $urandom_range(0, 12);
         if (k > 0) begin
            rsp_stall <= 1'b1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && !hold_off);
      end
   end

   // Sends one request beat after a random gap. The task is entered and left
   // at a rising edge; valid is lowered only for a gap before the beat.
   task automatic send_item(logic op, logic [IDX_W-1:0] first, logic [IDX_W-1:0] last,
                            logic [HIST_W-1:0] hist);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_first_index  <= first;
      req_last_index   <= last;
      req_digit_counts <= hist;
      do @(posedge clock); while (req_stall);
      board.note_request(op, first, last, hist);
   endtask

   // Waits until every query has been answered, then lets any assign still in
   // flight finish before the register is touched.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (LEAF_COUNT_DEF + 80) @(posedge clock);
   endtask

   // Write of used_leaves in a setup and an access phase; the register takes the
   // value at the access-cycle edge, which also starts the clearing pass.
   task automatic write_span(logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_USED_LEAVES;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      board.set_span(value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [HIST_W-1:0] random_hist();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '1;
         1: return '0;
         default: return raw[HIST_W-1:0];
      endcase
   endfunction

   // Mostly small ranges inside the span with random content; some ranges
   // spill past the end, some are empty, a few cover the whole array.
   task automatic random_item();
      int r;
      int a;
      int b;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         a = $urandom_range(0, board.span - 1);
         b = a + $urandom_range(0, 24);
         if (b > 1023) b = 1023;
      end else if (r < 85) begin
         a = $urandom_range(1, 1023);
         b = $urandom_range(0, a - 1);
      end else if (r < 90) begin
         a = 0;
         b = 1023;
      end else begin
         a = $urandom_range(0, 1023);
         b = $urandom_range(a, 1023);
      end
      send_item(($urandom_range(0, 2) == 0) ? OP_QUERY : logic'($urandom_range(0, 1)),
                a[IDX_W-1:0], b[IDX_W-1:0], random_hist());
   endtask

   initial begin
      int spans[6];
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ASSIGN;
      req_first_index = '0;
      req_last_index = '0;
      req_digit_counts = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst = 1'b0;
      hold_off = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset span of 1024 leaves. The clearing pass
      // after reset shows up as req_stall and is waited out by the handshake.
      send_item(OP_QUERY, 10'd0, 10'd1023, '0);
      send_item(OP_ASSIGN, 10'd0, 10'd0, '1);
      send_item(OP_ASSIGN, 10'd1023, 10'd1023, 60'h555_5555_5555_5555);
      send_item(OP_QUERY, 10'd0, 10'd1023, '0);
      send_item(OP_QUERY, 10'd1023, 10'd1023, '0);
      send_item(OP_QUERY, 10'd5, 10'd4, '1);
      send_item(OP_ASSIGN, 10'd9, 10'd3, '1);
      send_item(OP_ASSIGN, 10'd0, 10'd1023, '1);
      send_item(OP_QUERY, 10'd0, 10'd1023, '0);
      send_item(OP_ASSIGN, 10'd100, 10'd611, 60'hAAA_AAAA_AAAA_AAAA);
      send_item(OP_QUERY, 10'd50, 10'd700, '0);
      send_item(OP_QUERY, 10'd611, 10'd612, '0);
      drain();

      // A span of zero behaves as one leaf: ranges past it clip or go empty.
      write_span(32'd0);
      send_item(OP_ASSIGN, 10'd0, 10'd1023, '1);
      send_item(OP_QUERY, 10'd0, 10'd1023, '0);
      send_item(OP_QUERY, 10'd1, 10'd1023, '0);
      send_item(OP_QUERY, 10'd0, 10'd0, '0);
      drain();
      write_span(32'd3);
      send_item(OP_QUERY, 10'd0, 10'd2, '0);
      send_item(OP_ASSIGN, 10'd1, 10'd900, 60'h0FC_0FC0_FC0F_C0FC);
      send_item(OP_QUERY, 10'd0, 10'd1023, '0);
      send_item(OP_QUERY, 10'd3, 10'd3, '0);
      drain();

      // Random part over several spans, extremes included. Values above the
      // array size must clamp to 1024; bits above the used_leaves width are ignored.
      spans = '{2047, 37, 1, 2, 600, 1024};
      foreach (spans[p]) begin
         write_span((p == 0) ? 32'hFFFF_FFFF : spans[p]);
         burst = (p == 3);
         if (p == 5) hold_off = 1'b1;
         for (int i = 0; i < 115; i++) random_item();
         drain();
      end
      write_span({$urandom} | 32'd1);
      burst = 1'b0;
      for (int i = 0; i < 20; i++) random_item();

      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (LEAF_COUNT_DEF + 80) @(posedge clock);
      if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
